/* design/hpi_pkg.sv */
// shared types and constants of the hilbert point index unit
package hpi_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_X_LOW  = 2'd0;
	localparam logic [1:0] REG_Y_LOW  = 2'd1;
	localparam logic [1:0] REG_X_HIGH = 2'd2;
	localparam logic [1:0] REG_Y_HIGH = 2'd3;

	// bounding box after reset: -180..180 by -90..90 degrees, 20 fraction bits
	localparam logic signed [31:0] BOX_X_LOW_RST  = -32'sd188743680;
	localparam logic signed [31:0] BOX_Y_LOW_RST  = -32'sd94371840;
	localparam logic signed [31:0] BOX_X_HIGH_RST = 32'sd188743680;
	localparam logic signed [31:0] BOX_Y_HIGH_RST = 32'sd94371840;

	// fewest bits that hold the reset box edges
	localparam int BOX_MIN_WIDTH = 29;

	// grid geometry
	localparam int GRID_BITS = 16;
	localparam logic [GRID_BITS-1:0] GRID_MAX = 16'hFFFF;

	// lane numbers
	localparam int LANE_X = 0;
	localparam int LANE_Y = 1;

	// control word that travels with each point down the chain
	typedef struct packed {
		logic       valid;
		logic       clamped;
		logic [1:0] fix;   // grid value forced, per lane
		logic [1:0] full;  // forced value is the top of the grid, per lane
	} ctl_t;

endpackage

/* design/hpi_point_if.sv */
// point channel: valid, ready and the two coordinates
interface hpi_point_if #(
	parameter int COORD_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;

	modport source (output valid, point_x, point_y, input ready);
	modport sink (input valid, point_x, point_y, output ready);
endinterface

/* design/hpi_index_if.sv */
// result channel: valid, ready, curve index and clamp flag
interface hpi_index_if;
	logic        valid;
	logic        ready;
	logic [31:0] curve_index;
	logic        clamped;

	modport source (output valid, curve_index, clamped, input ready);
	modport sink (input valid, curve_index, clamped, output ready);
endinterface

/* design/hpi_norm.sv */
// front stages: box tests, offsets and the scaled dividend per lane
module hpi_norm
	import hpi_pkg::*;
#(
	parameter int AW = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    take,
	input  logic [1:0][AW-1:0]      coord,
	input  logic [1:0][AW-1:0]      low,
	input  logic [1:0][AW-1:0]      high,
	output ctl_t                    ctl_s2,
	output logic [1:0][AW-1:0]      rem_s2,
	output logic [1:0][GRID_BITS-1:0] nq_s2,
	output logic [1:0][AW-1:0]      range_s2
);

	logic [1:0]                lt_w;
	logic [1:0]                gt_w;
	logic [1:0]                lt_s1;
	logic [1:0]                gt_s1;
	logic                      valid_s1;
	logic [1:0][AW-1:0]        off_s1;
	logic [1:0][AW-1:0]        range_s1;
	logic [1:0][AW+GRID_BITS-1:0] prod_w;
	logic [1:0]                empty_w;

	// box tests per lane
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			lt_w[i] = $signed(coord[i]) < $signed(low[i]);
			gt_w[i] = $signed(coord[i]) > $signed(high[i]);
		end
	end

	// stage 1: flags, offset from the low edge and box width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lt_s1 <= lt_w;
			gt_s1 <= gt_w;
			for (int i = 0; i < 2; i++) begin
				off_s1[i]   <= coord[i] - low[i];
				range_s1[i] <= high[i] - low[i];
			end
		end
	end

	// offset times 65535, split into the upper remainder and low bits
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			prod_w[i]  = {off_s1[i], {GRID_BITS{1'b0}}} - {{GRID_BITS{1'b0}}, off_s1[i]};
			empty_w[i] = (range_s1[i] == '0);
		end
	end

	// stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2.valid   <= valid_s1;
			ctl_s2.clamped <= |(lt_s1 | gt_s1);
			ctl_s2.fix     <= lt_s1 | gt_s1 | empty_w;
			ctl_s2.full    <= gt_s1 & ~lt_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 2; i++) begin
				rem_s2[i]   <= prod_w[i][AW+GRID_BITS-1:GRID_BITS];
				nq_s2[i]    <= prod_w[i][GRID_BITS-1:0];
				range_s2[i] <= range_s1[i];
			end
		end
	end

endmodule

/* design/hpi_div_cell.sv */
// one cell of the divide chain: one quotient bit per lane
module hpi_div_cell
	import hpi_pkg::*;
#(
	parameter int AW = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  ctl_t                      ctl_in,
	input  logic [1:0][AW-1:0]        rem_in,
	input  logic [1:0][GRID_BITS-1:0] nq_in,
	input  logic [1:0][AW-1:0]        range_in,
	output ctl_t                      ctl_q,
	output logic [1:0][AW-1:0]        rem_q,
	output logic [1:0][GRID_BITS-1:0] nq_q,
	output logic [1:0][AW-1:0]        range_q
);

	logic [1:0][AW:0]          trial_w;
	logic [1:0]                ge_w;
	logic [1:0][AW:0]          diff_w;
	logic [1:0][AW-1:0]        rem_w;
	logic [1:0][GRID_BITS-1:0] nq_w;

	// shift in the next dividend bit, subtract the divisor where it fits
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			trial_w[i] = {rem_in[i], nq_in[i][GRID_BITS-1]};
			ge_w[i]    = trial_w[i] >= {1'b0, range_in[i]};
			diff_w[i]  = ge_w[i] ? trial_w[i] - {1'b0, range_in[i]} : trial_w[i];
			rem_w[i]   = diff_w[i][AW-1:0];
			nq_w[i]    = {nq_in[i][GRID_BITS-2:0], ge_w[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q   <= rem_w;
			nq_q    <= nq_w;
			range_q <= range_in;
		end
	end

endmodule

/* design/hpi_curve.sv */
// grid override and hilbert index by prefix scan and bit interleave
module hpi_curve
	import hpi_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  ctl_t                      ctl_in,
	input  logic [1:0][GRID_BITS-1:0] quot_in,
	output logic                      valid_q,
	output logic [31:0]               index_q,
	output logic                      clamped_q
);

	logic [1:0][GRID_BITS-1:0] grid_w;
	logic [31:0]               index_w;

	// spread sixteen bits to the even lanes of a word
	function automatic logic [31:0] spread16(input logic [15:0] v);
		logic [31:0] w;
		w = {16'h0000, v};
		w = (w | (w << 8)) & 32'h00FF00FF;
		w = (w | (w << 4)) & 32'h0F0F0F0F;
		w = (w | (w << 2)) & 32'h33333333;
		w = (w | (w << 1)) & 32'h55555555;
		return w;
	endfunction

	// forced grid values for clamped points and empty boxes
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			if (ctl_in.fix[i]) begin
				grid_w[i] = ctl_in.full[i] ? GRID_MAX : '0;
			end else begin
				grid_w[i] = quot_in[i];
			end
		end
	end

	// prefix scan of the curve states over shifts of 2, 4 and 8
	always_comb begin
		logic [15:0] gx, gy, qa, qb, qc, qd, pa, pb, pc, pd, ha, hb, lo, hi;
		int sh;
		gx = grid_w[LANE_X];
		gy = grid_w[LANE_Y];
		qa = gx ^ gy;
		qb = ~qa;
		qc = ~(gx | gy);
		qd = gx & ~gy;
		pa = qa | (qb >> 1);
		pb = (qa >> 1) ^ qa;
		pc = ((qc >> 1) ^ (qb & (qd >> 1))) ^ qc;
		pd = ((qa & (qc >> 1)) ^ (qd >> 1)) ^ qd;
		for (int k = 0; k < 3; k++) begin
			sh = 2 << k;
			qa = pa;
			qb = pb;
			qc = pc;
			qd = pd;
			pc = pc ^ (qa & (qc >> sh)) ^ (qb & (qd >> sh));
			pd = pd ^ (qb & (qc >> sh)) ^ ((qa ^ qb) & (qd >> sh));
			if (k < 2) begin
				pa = (qa & (qa >> sh)) ^ (qb & (qb >> sh));
				pb = (qa & (qb >> sh)) ^ (qb & ((qa ^ qb) >> sh));
			end
		end
		ha = pc ^ (pc >> 1);
		hb = pd ^ (pd >> 1);
		lo = gx ^ gy;
		hi = hb | ~(lo | ha);
		index_w = (spread16(hi) << 1) | spread16(lo);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= ctl_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			index_q   <= index_w;
			clamped_q <= ctl_in.clamped;
		end
	end

endmodule

/* design/hilbert_point_index_unit.sv */
// top level of the hilbert point index unit
//
//   channel   dir  handshake      payload
//   points    in   valid/ready    point_x, point_y (signed, 20 fraction bits)
//   indexes   out  valid/ready    curve_index[31:0], clamped
//   wr_*      in   wr_en          wr_index[1:0], wr_data (box edges)
//
// one point per cycle while the output is not stalled; a point passes
// two front stages, a chain of 16 divide cells (one quotient bit each),
// the curve stage and the output register. reset loads the
// -180..180 by -90..90 box and empties the chain. while the output skid
// register is occupied the whole chain holds and points.ready is low; ready
// comes straight from a register.
module hilbert_point_index_unit
	import hpi_pkg::*;
#(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	hpi_point_if.sink                     points,
	hpi_index_if.source                   indexes,
	input  logic                          wr_en,
	input  logic [1:0]                    wr_index,
	input  logic signed [COORD_WIDTH-1:0] wr_data
);

	// box edges are kept wide enough for the reset values
	localparam int AW = (COORD_WIDTH > BOX_MIN_WIDTH) ? COORD_WIDTH : BOX_MIN_WIDTH;
	localparam int CELLS = GRID_BITS;

	logic signed [AW-1:0] x_low_q, y_low_q, x_high_q, y_high_q;
	logic signed [AW-1:0] wr_ext;

	logic                 en;
	logic                 take;
	logic [1:0][AW-1:0]   coord;
	logic [1:0][AW-1:0]   low;
	logic [1:0][AW-1:0]   high;

	ctl_t                        ctl_c   [CELLS+1];
	logic [1:0][AW-1:0]          rem_c   [CELLS+1];
	logic [1:0][GRID_BITS-1:0]   nq_c    [CELLS+1];
	logic [1:0][AW-1:0]          range_c [CELLS+1];

	logic        cv_valid;
	logic [31:0] cv_index;
	logic        cv_clamped;

	logic        out_valid_q, skid_valid_q;
	logic [31:0] out_index_q, skid_index_q;
	logic        out_clamped_q, skid_clamped_q;

	// box registers
	assign wr_ext = AW'(wr_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_low_q  <= AW'(BOX_X_LOW_RST);
			y_low_q  <= AW'(BOX_Y_LOW_RST);
			x_high_q <= AW'(BOX_X_HIGH_RST);
			y_high_q <= AW'(BOX_Y_HIGH_RST);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_X_LOW:  x_low_q  <= wr_ext;
				REG_Y_LOW:  y_low_q  <= wr_ext;
				REG_X_HIGH: x_high_q <= wr_ext;
				REG_Y_HIGH: y_high_q <= wr_ext;
				default: ;
			endcase
		end
	end

	// chain advances whenever the skid register is free
	assign en           = !skid_valid_q;
	assign points.ready = en;
	assign take         = points.valid;

	assign coord[LANE_X] = AW'(points.point_x);
	assign coord[LANE_Y] = AW'(points.point_y);
	assign low[LANE_X]   = x_low_q;
	assign low[LANE_Y]   = y_low_q;
	assign high[LANE_X]  = x_high_q;
	assign high[LANE_Y]  = y_high_q;

	hpi_norm #(
		.AW(AW)
	) u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.take     (take),
		.coord    (coord),
		.low      (low),
		.high     (high),
		.ctl_s2   (ctl_c[0]),
		.rem_s2   (rem_c[0]),
		.nq_s2    (nq_c[0]),
		.range_s2 (range_c[0])
	);

	// divide chain: one quotient bit per cell, msb first
	for (genvar g = 0; g < CELLS; g++) begin : g_cell
		hpi_div_cell #(
			.AW(AW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.ctl_in   (ctl_c[g]),
			.rem_in   (rem_c[g]),
			.nq_in    (nq_c[g]),
			.range_in (range_c[g]),
			.ctl_q    (ctl_c[g+1]),
			.rem_q    (rem_c[g+1]),
			.nq_q     (nq_c[g+1]),
			.range_q  (range_c[g+1])
		);
	end

	hpi_curve u_curve (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.ctl_in    (ctl_c[CELLS]),
		.quot_in   (nq_c[CELLS]),
		.valid_q   (cv_valid),
		.index_q   (cv_index),
		.clamped_q (cv_clamped)
	);

	// output register with skid: a result meets a stalled output only when
	// the chain still moved, so the skid slot is always free then
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (indexes.ready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || indexes.ready) begin
			out_valid_q <= cv_valid;
		end else if (cv_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (indexes.ready) begin
				out_index_q   <= skid_index_q;
				out_clamped_q <= skid_clamped_q;
			end
		end else if (!out_valid_q || indexes.ready) begin
			out_index_q   <= cv_index;
			out_clamped_q <= cv_clamped;
		end else begin
			skid_index_q   <= cv_index;
			skid_clamped_q <= cv_clamped;
		end
	end

	assign indexes.valid       = out_valid_q;
	assign indexes.curve_index = out_index_q;
	assign indexes.clamped     = out_clamped_q;

endmodule
